### src/occupancy_light_timer_macros.svh
// Assertion macros of the occupancy light timer datapath.
`ifndef OCCUPANCY_LIGHT_TIMER_MACROS_SVH
`define OCCUPANCY_LIGHT_TIMER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define OLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define OLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/olt_pkg.sv
// Types and constants of the occupancy light timer.
package olt_pkg;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_MOTION = 3'd1,
        REQ_AUTO   = 3'd2,
        REQ_ON     = 3'd3,
        REQ_OFF    = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        CFG_HOLD       = 3'd0,
        CFG_ACT_GAIN   = 3'd1,
        CFG_ACT_CAP    = 3'd2,
        CFG_REC_GAIN   = 3'd3,
        CFG_REC_WINDOW = 3'd4,
        CFG_ENERGY     = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EFF,
        OP_SEL,
        OP_SCALE,
        OP_MOTION,
        OP_MODQ,
        OP_MODR,
        OP_TICK,
        OP_BUTTON,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take_in;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       manual;
        logic       has_deadline;
        logic       out_free;
    } t_status;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] REPORT_PERIOD_MS = 32'd10000;
    // floor(x / 10000) = (x * RECIP_10K) >> 45 for any 32-bit x
    localparam logic [31:0] RECIP_10K        = 32'hD1B7_1759;
    // floor(x / 3) = (x * RECIP_3) >> 33 for any 32-bit x
    localparam logic [31:0] RECIP_3          = 32'hAAAA_AAAB;
    localparam logic [8:0]  ACTIVITY_MAX     = 9'd511;
    localparam logic [63:0] ROUND_HALF       = 64'd128;

    localparam logic [31:0] RST_HOLD       = 32'd60000;
    localparam logic [15:0] RST_ACT_GAIN   = 16'd205;
    localparam logic [7:0]  RST_ACT_CAP    = 8'd2;
    localparam logic [15:0] RST_REC_GAIN   = 16'd563;
    localparam logic [15:0] RST_REC_WINDOW = 16'd2000;
    localparam logic [1:0]  RST_ENERGY     = 2'd0;

endpackage

### src/olt_req_if.sv
// Request channel: event type and current time.
interface olt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] now_ms;

    modport source (output valid, output req_type, output now_ms, input ready);
    modport sink   (input valid, input req_type, input now_ms, output ready);
endinterface

### src/olt_res_if.sv
// Result channel: lamp, mode, deadline and report pulse.
interface olt_res_if;
    logic        valid;
    logic        ready;
    logic        lamp_on;
    logic        manual_mode;
    logic [31:0] off_deadline_ms;
    logic        report_time_left;

    modport source (output valid, output lamp_on, output manual_mode,
                    output off_deadline_ms, output report_time_left, input ready);
    modport sink   (input valid, input lamp_on, input manual_mode,
                    input off_deadline_ms, input report_time_left, output ready);
endinterface

### src/olt_ctrl.sv
// Sequencer of the light timer: steps the datapath through each word.
module olt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  olt_pkg::t_status i_status,
    output logic             o_in_ready,
    output olt_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EFF,
        S_SEL,
        S_SCALE,
        S_MOTION,
        S_MODQ,
        S_MODR,
        S_TICK,
        S_BUTTON,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_status.req == olt_pkg::REQ_MOTION && !i_status.manual) begin
                    n_state = S_EFF;
                end else if (i_status.req == olt_pkg::REQ_TICK && !i_status.manual
                             && i_status.has_deadline) begin
                    n_state = S_MODQ;
                end else begin
                    n_state = S_BUTTON;
                end
            end
            S_EFF:    n_state = S_SEL;
            S_SEL:    n_state = S_SCALE;
            S_SCALE:  n_state = S_MOTION;
            S_MOTION: n_state = S_LOAD;
            S_MODQ:   n_state = S_MODR;
            S_MODR:   n_state = S_TICK;
            S_TICK:   n_state = S_LOAD;
            S_BUTTON: n_state = S_LOAD;
            S_LOAD: begin
                // hold until the output register can take the word
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.take_in = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_EFF:    o_cmd.op = olt_pkg::OP_EFF;
            S_SEL:    o_cmd.op = olt_pkg::OP_SEL;
            S_SCALE:  o_cmd.op = olt_pkg::OP_SCALE;
            S_MOTION: o_cmd.op = olt_pkg::OP_MOTION;
            S_MODQ:   o_cmd.op = olt_pkg::OP_MODQ;
            S_MODR:   o_cmd.op = olt_pkg::OP_MODR;
            S_TICK:   o_cmd.op = olt_pkg::OP_TICK;
            S_BUTTON: o_cmd.op = olt_pkg::OP_BUTTON;
            S_LOAD:   o_cmd.op = olt_pkg::OP_LOAD;
            default:  o_cmd.op = olt_pkg::OP_NONE;
        endcase
    end

endmodule

### src/olt_datapath.sv
// Datapath of the light timer: settings, timer state, shared multiplier, output register.
`include "occupancy_light_timer_macros.svh"

module olt_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [olt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [olt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  olt_pkg::t_cmd                  i_cmd,
    input  logic [2:0]                     i_req_type,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_res_ready,
    output olt_pkg::t_status               o_status,
    output logic                           o_res_valid,
    output logic                           o_lamp_on,
    output logic                           o_manual_mode,
    output logic [31:0]                    o_off_deadline_ms,
    output logic                           o_report_time_left
);

    // settings
    logic [31:0] r_hold;
    logic [15:0] r_act_gain;
    logic [7:0]  r_act_cap;
    logic [15:0] r_rec_gain;
    logic [15:0] r_rec_window;
    logic [1:0]  r_energy;

    // timer state
    logic        r_manual;
    logic        r_relay;
    logic [31:0] r_deadline;
    logic [31:0] r_last_off;
    logic [8:0]  r_count;

    // word in flight
    logic [2:0]  r_req;
    logic [31:0] r_now;
    logic        r_report;
    logic [31:0] r_eff;
    logic        r_recall;
    logic        r_use_act;
    logic [63:0] r_prod;

    // output register
    logic        r_out_valid;
    logic        r_out_relay;
    logic        r_out_manual;
    logic [31:0] r_out_deadline;
    logic        r_out_report;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] diff;
    logic [7:0]  cnt_clamp;
    logic        recall_hit;
    logic        act_hit;
    logic [63:0] rounded;
    logic [31:0] extension;
    logic [31:0] n_deadline;
    logic [31:0] eff_sel;
    logic        out_free;
    logic        op_motion;
    logic        load_now;
    logic        auto_tick;

    assign diff       = r_deadline - r_now;
    assign cnt_clamp  = (r_count > {1'b0, r_act_cap}) ? r_act_cap : r_count[7:0];
    assign recall_hit = (r_last_off != 32'd0)
                        && ((r_now - r_last_off) < {16'd0, r_rec_window});
    assign act_hit    = !recall_hit && (r_count != 9'd0);
    assign rounded    = r_prod + olt_pkg::ROUND_HALF;
    assign extension  = rounded[39:8];
    assign n_deadline = r_now + r_eff + extension;
    assign out_free   = !r_out_valid || i_res_ready;
    assign op_motion  = (i_cmd.op == olt_pkg::OP_MOTION);
    assign load_now   = (i_cmd.op == olt_pkg::OP_LOAD) && out_free;
    assign auto_tick  = (r_req == olt_pkg::REQ_TICK) && !r_manual;

    always_comb begin
        case (r_energy)
            2'd0:    eff_sel = r_hold;
            2'd1:    eff_sel = {1'b0, r_hold[31:1]};
            2'd2:    eff_sel = {1'b0, r_prod[63:33]};
            default: eff_sel = {2'b0, r_hold[31:2]};
        endcase
    end

    // one shared 32x32 multiplier, product registered every cycle
    always_comb begin
        case (i_cmd.op)
            olt_pkg::OP_EFF: begin
                mul_a = r_hold;
                mul_b = olt_pkg::RECIP_3;
            end
            olt_pkg::OP_SEL: begin
                mul_a = {24'd0, cnt_clamp};
                mul_b = {16'd0, r_act_gain};
            end
            olt_pkg::OP_SCALE: begin
                mul_a = r_eff;
                if (r_recall) begin
                    mul_b = {16'd0, r_rec_gain};
                end else if (r_use_act) begin
                    mul_b = {8'd0, r_prod[23:0]};
                end else begin
                    mul_b = 32'd0;
                end
            end
            olt_pkg::OP_MODQ: begin
                mul_a = diff;
                mul_b = olt_pkg::RECIP_10K;
            end
            olt_pkg::OP_MODR: begin
                mul_a = {13'd0, r_prod[63:45]};
                mul_b = olt_pkg::REPORT_PERIOD_MS;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= olt_pkg::RST_HOLD;
            r_act_gain   <= olt_pkg::RST_ACT_GAIN;
            r_act_cap    <= olt_pkg::RST_ACT_CAP;
            r_rec_gain   <= olt_pkg::RST_REC_GAIN;
            r_rec_window <= olt_pkg::RST_REC_WINDOW;
            r_energy     <= olt_pkg::RST_ENERGY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                olt_pkg::CFG_HOLD:       r_hold       <= i_cfg_data;
                olt_pkg::CFG_ACT_GAIN:   r_act_gain   <= i_cfg_data[15:0];
                olt_pkg::CFG_ACT_CAP:    r_act_cap    <= i_cfg_data[7:0];
                olt_pkg::CFG_REC_GAIN:   r_rec_gain   <= i_cfg_data[15:0];
                olt_pkg::CFG_REC_WINDOW: r_rec_window <= i_cfg_data[15:0];
                olt_pkg::CFG_ENERGY:     r_energy     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == olt_pkg::OP_SEL) begin
            r_eff     <= eff_sel;
            r_recall  <= recall_hit;
            r_use_act <= act_hit;
        end
        if (i_cmd.take_in) begin
            r_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual   <= 1'b0;
            r_relay    <= 1'b0;
            r_deadline <= 32'd0;
            r_last_off <= 32'd0;
            r_count    <= 9'd0;
            r_req      <= olt_pkg::REQ_TICK;
            r_report   <= 1'b0;
        end else begin
            if (i_cmd.take_in) begin
                r_req    <= i_req_type;
                r_report <= 1'b0;
            end
            case (i_cmd.op)
                olt_pkg::OP_SEL: begin
                    // clamp the count only on the activity path
                    if (act_hit) r_count <= {1'b0, cnt_clamp};
                end
                olt_pkg::OP_MOTION: begin
                    if (n_deadline > r_deadline) r_deadline <= n_deadline;
                    if (r_count < olt_pkg::ACTIVITY_MAX) r_count <= r_count + 9'd1;
                    r_relay <= 1'b1;
                end
                olt_pkg::OP_TICK: begin
                    r_report <= (r_prod[31:0] == diff);
                    if (r_now > r_deadline) begin
                        r_relay    <= 1'b0;
                        r_count    <= 9'd0;
                        r_deadline <= 32'd0;
                        r_last_off <= r_now;
                    end
                end
                olt_pkg::OP_BUTTON: begin
                    case (r_req)
                        olt_pkg::REQ_AUTO: begin
                            r_manual   <= 1'b0;
                            r_relay    <= 1'b0;
                            r_count    <= 9'd0;
                            r_deadline <= 32'd0;
                            r_last_off <= r_now;
                        end
                        olt_pkg::REQ_ON: begin
                            r_manual <= 1'b1;
                            r_relay  <= 1'b1;
                        end
                        olt_pkg::REQ_OFF: begin
                            r_manual <= 1'b1;
                            r_relay  <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == olt_pkg::OP_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.op == olt_pkg::OP_LOAD && out_free) begin
            r_out_relay    <= r_relay;
            r_out_manual   <= r_manual;
            r_out_deadline <= r_deadline;
            r_out_report   <= r_report;
        end
    end

    assign o_status.req          = r_req;
    assign o_status.manual       = r_manual;
    assign o_status.has_deadline = (r_deadline != 32'd0);
    assign o_status.out_free     = out_free;

    assign o_res_valid        = r_out_valid;
    assign o_lamp_on          = r_out_relay;
    assign o_manual_mode      = r_out_manual;
    assign o_off_deadline_ms  = r_out_deadline;
    assign o_report_time_left = r_out_report;

    `OLT_ASSERT_NEXT(a_motion_relay_on, op_motion, r_relay, "motion left relay off")
    `OLT_ASSERT_NEXT(a_no_pull_in, op_motion, r_deadline >= $past(r_deadline), "deadline lowered")
    `OLT_ASSERT_NOW(a_report_on_tick, r_report, auto_tick, "report outside auto tick")
    `OLT_ASSERT_NEXT(a_load_relay, load_now, r_out_valid && r_out_relay == $past(r_relay), "relay lost")

endmodule

### src/occupancy_light_timer.sv
// Top level of the occupancy light timer: sequencer and datapath.
//
// Takes one request word at a time and returns one result word per request.
// A button press or an inert tick steps through decode, button and load; in
// auto mode a tick with a deadline set and a motion event also pass through
// the single shared 32x32 multiplier (divide by three, gain times count,
// timeout scaling, and two passes for the 10-second report check). A finished
// result sits in the output register, so a new request is accepted while it
// waits to be taken. Settings must be written through the write port only
// while no request is in flight; the block itself does not enforce this.
module occupancy_light_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [olt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [olt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    olt_req_if.sink                        i_req,
    olt_res_if.source                      o_res
);

    olt_pkg::t_cmd    cmd;
    olt_pkg::t_status status;
    logic             in_ready;

    olt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    olt_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .i_req_type         (i_req.req_type),
        .i_now_ms           (i_req.now_ms),
        .i_res_ready        (o_res.ready),
        .o_status           (status),
        .o_res_valid        (o_res.valid),
        .o_lamp_on          (o_res.lamp_on),
        .o_manual_mode      (o_res.manual_mode),
        .o_off_deadline_ms  (o_res.off_deadline_ms),
        .o_report_time_left (o_res.report_time_left)
    );

    assign i_req.ready = in_ready;

endmodule

### dv/occupancy_light_timer_test.sv
// Self-checking testbench of the occupancy light timer: predicted result words against the block.
module occupancy_light_timer_test;

    typedef struct packed {
        logic        lamp_on;
        logic        manual_mode;
        logic [31:0] off_deadline_ms;
        logic        report_time_left;
    } t_light_word;

    localparam logic [2:0] REQ_CODE_MAX = 3'd7;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int BURST_ITEMS  = 515;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int MAX_GAP      = 40;

    // Light timer state and settings, advanced once per accepted request word
    class t_light_timer_board;
        logic [31:0] hold_ms;
        logic [15:0] act_gain;
        logic [7:0]  act_cap;
        logic [15:0] rec_gain;
        logic [15:0] rec_window;
        logic [1:0]  energy;

        logic        manual_flag;
        logic        relay_state;
        logic [31:0] deadline;
        logic [31:0] last_off;
        logic [8:0]  activity;

        t_light_word awaited[$];
        int errors, requests, words_seen;
        int reports, switch_offs, recalls, extensions;

        function new();
            hold_ms     = olt_pkg::RST_HOLD;
            act_gain    = olt_pkg::RST_ACT_GAIN;
            act_cap     = olt_pkg::RST_ACT_CAP;
            rec_gain    = olt_pkg::RST_REC_GAIN;
            rec_window  = olt_pkg::RST_REC_WINDOW;
            energy      = olt_pkg::RST_ENERGY;
            manual_flag = 1'b0;
            relay_state = 1'b0;
            deadline    = '0;
            last_off    = '0;
            activity    = '0;
            errors      = 0;
            requests    = 0;
            words_seen  = 0;
            reports     = 0;
            switch_offs = 0;
            recalls     = 0;
            extensions  = 0;
        endfunction

        function void write_reg(olt_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                olt_pkg::CFG_HOLD:       hold_ms    = data;
                olt_pkg::CFG_ACT_GAIN:   act_gain   = data[15:0];
                olt_pkg::CFG_ACT_CAP:    act_cap    = data[7:0];
                olt_pkg::CFG_REC_GAIN:   rec_gain   = data[15:0];
                olt_pkg::CFG_REC_WINDOW: rec_window = data[15:0];
                olt_pkg::CFG_ENERGY:     energy     = data[1:0];
                default: ;
            endcase
        endfunction

        // Q8.8 product back to integer, rounding half up
        function logic [31:0] round_q8(logic [63:0] product);
            logic [63:0] shifted;
            shifted = (product + olt_pkg::ROUND_HALF) >> 8;
            return shifted[31:0];
        endfunction

        function void clear_timer(logic [31:0] now);
            relay_state = 1'b0;
            activity    = '0;
            deadline    = '0;
            last_off    = now;
        endfunction

        function void take_request(logic [2:0] req, logic [31:0] now);
            logic        report;
            logic [31:0] left, eff, since, n;
            report = 1'b0;
            requests++;
            case (req)
                olt_pkg::REQ_TICK: begin
                    if (!manual_flag && deadline != 0) begin
                        left = deadline - now;
                        if (left % olt_pkg::REPORT_PERIOD_MS == 0) begin
                            report = 1'b1;
                            reports++;
                        end
                        if (now > deadline) begin
                            clear_timer(now);
                            switch_offs++;
                        end
                    end
                end
                olt_pkg::REQ_MOTION: begin
                    if (!manual_flag) begin
                        eff   = hold_ms / (32'(energy) + 32'd1);
                        n     = now + eff;
                        since = now - last_off;
                        if (last_off != 0 && since < 32'(rec_window)) begin
                            n = n + round_q8(64'(eff) * 64'(rec_gain));
                            recalls++;
                        end else if (activity >= 1) begin
                            // clamp the count before it scales the extension
                            if (activity > 9'(act_cap))
                                activity = 9'(act_cap);
                            n = n + round_q8(64'(eff) * 64'(act_gain) * 64'(activity));
                            extensions++;
                        end
                        if (n > deadline)
                            deadline = n;
                        if (activity < olt_pkg::ACTIVITY_MAX)
                            activity = activity + 9'd1;
                        relay_state = 1'b1;
                    end
                end
                olt_pkg::REQ_AUTO: begin
                    manual_flag = 1'b0;
                    clear_timer(now);
                end
                olt_pkg::REQ_ON: begin
                    manual_flag = 1'b1;
                    relay_state = 1'b1;
                end
                olt_pkg::REQ_OFF: begin
                    manual_flag = 1'b1;
                    relay_state = 1'b0;
                end
                default: ;
            endcase
            awaited.push_back('{relay_state, manual_flag, deadline, report});
        endfunction

        function void flag_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_word(t_light_word got);
            t_light_word want;
            words_seen++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing awaited: expected none, got %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            flag_field("lamp_on", 32'(want.lamp_on), 32'(got.lamp_on));
            flag_field("manual_mode", 32'(want.manual_mode), 32'(got.manual_mode));
            flag_field("off_deadline_ms", want.off_deadline_ms, got.off_deadline_ms);
            flag_field("report_time_left", 32'(want.report_time_left),
                       32'(got.report_time_left));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [olt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [olt_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             src_idle_pct = 0;
    int                             sink_stall_pct = 0;
    int                             cycle_count = 0;
    logic [31:0]                    wall_ms;
    t_light_timer_board             board = new();

    olt_req_if req_bus();
    olt_res_if res_bus();

    occupancy_light_timer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_bus),
        .o_res      (res_bus)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Take result words, stalling at the rate of the current phase
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready)
                board.check_word({res_bus.lamp_on, res_bus.manual_mode,
                                  res_bus.off_deadline_ms, res_bus.report_time_left});
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end else begin
            res_bus.ready <= 1'b0;
        end
    end

    task automatic send_word(logic [2:0] req, logic [31:0] now);
        int gaps = 0;
        while (gaps < MAX_GAP && $urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
            gaps++;
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= req;
        req_bus.now_ms   <= now;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        board.take_request(req, now);
    endtask

    task automatic program_regs(logic [31:0] hold, logic [31:0] gain_a, logic [31:0] cap,
                                logic [31:0] gain_r, logic [31:0] window,
                                logic [31:0] level);
        olt_pkg::t_cfg_idx idxs[6];
        logic [31:0]       vals[6];
        idxs = '{olt_pkg::CFG_HOLD, olt_pkg::CFG_ACT_GAIN, olt_pkg::CFG_ACT_CAP,
                 olt_pkg::CFG_REC_GAIN, olt_pkg::CFG_REC_WINDOW, olt_pkg::CFG_ENERGY};
        vals = '{hold, gain_a, cap, gain_r, window, level};
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
            board.write_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic wait_all_taken();
        while (board.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed traffic around the live deadline and switch-off time
    task automatic next_random(output logic [2:0] req, output logic [31:0] now);
        int          roll;
        logic [31:0] dl;
        roll = $urandom_range(99);
        dl   = board.deadline;
        if (board.manual_flag && roll < 25) begin
            req = olt_pkg::REQ_AUTO;
            now = wall_ms + $urandom_range(500);
        end else if (roll < 28) begin
            req = olt_pkg::REQ_MOTION;
            now = wall_ms + $urandom_range(1500);
        end else if (roll < 38) begin
            req = olt_pkg::REQ_MOTION;
            now = board.last_off + $urandom_range(32'(board.rec_window) + 100);
        end else if (roll < 52) begin
            req = olt_pkg::REQ_TICK;
            now = wall_ms + $urandom_range(20000);
        end else if (roll < 62) begin
            req = olt_pkg::REQ_TICK;
            now = dl - olt_pkg::REPORT_PERIOD_MS * $urandom_range(4);
        end else if (roll < 70) begin
            req = olt_pkg::REQ_TICK;
            now = dl + $urandom_range(3000, 1);
        end else if (roll < 78) begin
            req = olt_pkg::REQ_AUTO;
            now = wall_ms + $urandom_range(3000);
        end else if (roll < 83) begin
            req = olt_pkg::REQ_ON;
            now = wall_ms;
        end else if (roll < 88) begin
            req = olt_pkg::REQ_OFF;
            now = wall_ms;
        end else if (roll < 92) begin
            req = 3'($urandom_range(REQ_CODE_MAX, 32'(olt_pkg::REQ_OFF) + 1));
            now = $urandom;
        end else begin
            req = 3'($urandom_range(REQ_CODE_MAX));
            now = $urandom;
        end
        if (roll < 88)
            wall_ms = now;
    endtask

    initial begin
        logic [2:0]  req;
        logic [31:0] now;
        logic [31:0] base;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= olt_pkg::CFG_HOLD;
        cfg_data         <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= olt_pkg::REQ_TICK;
        req_bus.now_ms   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset settings
        send_word(olt_pkg::REQ_TICK, 32'd0);
        send_word(olt_pkg::REQ_MOTION, 32'd1000);
        send_word(olt_pkg::REQ_MOTION, 32'd1500);
        send_word(olt_pkg::REQ_MOTION, 32'd2000);
        send_word(olt_pkg::REQ_MOTION, 32'd2500);
        send_word(olt_pkg::REQ_TICK, board.deadline - 32'd20000);
        send_word(olt_pkg::REQ_TICK, board.deadline);
        send_word(olt_pkg::REQ_TICK, board.deadline + 32'd1);
        send_word(olt_pkg::REQ_MOTION, board.last_off + 32'd1999);
        send_word(olt_pkg::REQ_TICK, board.deadline + 32'd7);
        send_word(olt_pkg::REQ_MOTION, board.last_off + 32'd2000);
        send_word(olt_pkg::REQ_OFF, 32'd1);
        send_word(olt_pkg::REQ_MOTION, 32'd5);
        send_word(olt_pkg::REQ_TICK, 32'hFFFF_FFFF);
        send_word(olt_pkg::REQ_ON, 32'd7);
        send_word(olt_pkg::REQ_AUTO, 32'd0);
        send_word(olt_pkg::REQ_MOTION, 32'd100);
        send_word(olt_pkg::REQ_MOTION, 32'hFFFF_FFFF);
        send_word(olt_pkg::REQ_TICK, 32'hFFFF_FFFF);
        send_word(olt_pkg::REQ_MOTION, 32'd100);
        for (int c = 32'(olt_pkg::REQ_OFF) + 1; c <= 32'(REQ_CODE_MAX); c++)
            send_word(3'(c), $urandom);
        send_word(olt_pkg::REQ_AUTO, 32'hAAAA_5555);
        req_bus.valid <= 1'b0;
        wait_all_taken();

        for (int p = 0; p < PHASES; p++) begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            wall_ms        = $urandom_range(1000000, 1);
            case (p)
                1: program_regs($urandom_range(30000, 1000), $urandom_range(1024),
                                $urandom_range(6), $urandom_range(1024),
                                $urandom_range(5000, 500), $urandom_range(3));
                2: program_regs(32'hFFFF_FFFF, 32'hFFFF, 32'hFF, 32'hFFFF, 32'hFFFF, 32'd3);
                3: program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                4: program_regs($urandom_range(30000, 1000), $urandom_range(65535),
                                $urandom_range(255), $urandom_range(65535),
                                $urandom_range(65535), $urandom_range(2));
                5: begin
                    program_regs(32'hFFFF_FFFF - $urandom_range(1000), $urandom_range(65535),
                                 $urandom_range(255), $urandom_range(65535),
                                 $urandom_range(65535), 32'd2);
                    // start close to the top of the time range so sums wrap
                    wall_ms = 32'hFFFF_0000 + $urandom_range(32'hFFFF);
                end
                6: program_regs($urandom_range(20000, 500), $urandom_range(2048),
                                $urandom_range(8), $urandom_range(2048),
                                $urandom_range(4000), 32'd3);
                7: program_regs(olt_pkg::RST_HOLD, olt_pkg::RST_ACT_GAIN,
                                olt_pkg::RST_ACT_CAP, olt_pkg::RST_REC_GAIN,
                                olt_pkg::RST_REC_WINDOW, olt_pkg::RST_ENERGY);
                default: ;
            endcase
            case (p % 4)
                1: src_idle_pct = 73;
                2: sink_stall_pct = 73;
                3: begin
                    src_idle_pct   = 7;
                    sink_stall_pct = 7;
                end
                default: ;
            endcase

            if (p == 2) begin
                // hold inside the recall window long enough to saturate the count
                base = $urandom_range(32'h7FFF_FFFF, 1);
                send_word(olt_pkg::REQ_AUTO, base);
                for (int i = 1; i <= BURST_ITEMS; i++)
                    send_word(olt_pkg::REQ_MOTION, base + 32'(i * 10));
            end else begin
                for (int i = 0; i < PHASE_ITEMS; i++) begin
                    next_random(req, now);
                    send_word(req, now);
                end
            end
            req_bus.valid <= 1'b0;
            wait_all_taken();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.awaited.size() != 0) begin
            board.errors++;
            $display("%0t: %0d result words still awaited at the end", $time,
                     board.awaited.size());
        end
        $display("Checked %0d result words for %0d requests over eight register settings",
                 board.words_seen, board.requests);
        $display("with and without idling; %0d reports, %0d switch-offs, %0d recall, %0d activity",
                 board.reports, board.switch_offs, board.recalls, board.extensions);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
